[rtl/ist_pkg.sv]
`timescale 1ns / 1ps
package ist_pkg;
   localparam int CAPACITY_DEF  = 16;
   localparam int POS_WIDTH_DEF = 32;
   localparam int MAX_OUT       = 16;
   localparam int CMD_WIDTH     = 2;
   localparam int INDEX_WIDTH   = 6;
   localparam int COUNT_WIDTH   = 7;
   localparam int FIELD_WIDTH   = 32;

   typedef enum logic [1:0] {
      CMD_ADD       = 2'd0,
      CMD_SUBTRACT  = 2'd1,
      CMD_INTERSECT = 2'd2,
      CMD_READ      = 2'd3
   } cmd_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // capture the request word
      logic scan_clear; // reset scan index and accumulators
      logic scan_step;  // examine the stored entry at the scan index
      logic read_issue; // present the read index to the stores
      logic emit_hold;  // hold the current piece until the next one or the end
      logic commit;     // swap in the rebuilt list
   } ist_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;  // scan index has reached the stored count
      logic empty_rng;  // ordered range is empty
      logic add_full;   // add-full flag, tied low: add overflow is caught at commit
      logic sub_full;   // subtract-full flag, tied low: overflow is caught at commit
      logic piece_hit;  // current entry gives an intersect piece
      logic out_limit;  // intersect has given its last allowed piece
   } ist_sts_type;
endpackage

[rtl/ist_ram.sv]
`timescale 1ns / 1ps
module ist_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

[rtl/ist_datapath.sv]
`timescale 1ns / 1ps
module ist_datapath #(
   parameter int CAPACITY  = ist_pkg::CAPACITY_DEF,
   parameter int POS_WIDTH = ist_pkg::POS_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ist_pkg::ist_cmd_type                cmd,
   output ist_pkg::ist_sts_type                sts,
   input  logic [ist_pkg::CMD_WIDTH-1:0]       req_cmd,
   input  logic [ist_pkg::FIELD_WIDTH-1:0]     req_start,
   input  logic [ist_pkg::FIELD_WIDTH-1:0]     req_end,
   input  logic [ist_pkg::INDEX_WIDTH-1:0]     req_index,
   output logic [ist_pkg::CMD_WIDTH-1:0]       op,
   output logic [ist_pkg::FIELD_WIDTH-1:0]     piece_start,
   output logic [ist_pkg::FIELD_WIDTH-1:0]     piece_end,
   output logic                                read_found,
   output logic                                ovf,
   output logic [ist_pkg::COUNT_WIDTH-1:0]     count
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = POS_WIDTH;
   localparam int OCW = $clog2(ist_pkg::MAX_OUT + 1);

   // Two banks per store: the list is rebuilt into the inactive bank and the
   // banks swap on commit.
   logic            bank_ff, bank_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [CW:0]     wcount_ff, wcount_in;
   logic [CW-1:0]   scan_ff, scan_in;
   logic [PW-1:0]   s_ff, e_ff, ns_ff, ne_ff, ns_in, ne_in;
   logic [CW-1:0]   merged_ff, merged_in;
   logic            placed_ff, placed_in;
   logic [1:0]      op_ff;
   logic [ist_pkg::INDEX_WIDTH-1:0] idx_ff;
   logic            ovf_ff, ovf_in;
   logic [OCW-1:0]  outs_ff, outs_in;
   logic [PW-1:0]   pc_s_ff, pc_e_ff;
   logic [PW-1:0]   a, b;
   logic [PW-1:0]   ra_s [2], ra_e [2];
   logic [AW-1:0]   raddr;
   logic            we;
   logic [AW-1:0]   waddr;
   logic [PW-1:0]   wds, wde;
   logic [PW-1:0]   lo, hi;
   logic [PW-1:0]   rs, re;

   assign rs = PW'(req_start[(PW > 32 ? 32 : PW)-1:0]);
   assign re = PW'(req_end[(PW > 32 ? 32 : PW)-1:0]);
   assign raddr = cmd.read_issue ? idx_ff[AW-1:0] : scan_in[AW-1:0];

   for (genvar g = 0; g < 2; g++) begin : g_bank
      ist_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_s (
         .clock(clock), .wr_en(we && (bank_ff != 1'(g))), .wr_addr(waddr),
         .wr_data(wds), .rd_addr(raddr), .rd_data(ra_s[g]));
      ist_ram #(.WIDTH(PW), .DEPTH(CAPACITY)) u_e (
         .clock(clock), .wr_en(we && (bank_ff != 1'(g))), .wr_addr(waddr),
         .wr_data(wde), .rd_addr(raddr), .rd_data(ra_e[g]));
   end

   assign a = ra_s[bank_ff];
   assign b = ra_e[bank_ff];
   assign lo = (a > s_ff) ? a : s_ff;
   assign hi = (b < e_ff) ? b : e_ff;

   // Add and subtract write at most two entries per scanned entry; the second
   // one goes out in the following fetch cycle from the pending register below.
   logic            pend_ff, pend_in;
   logic [PW-1:0]   pds_ff, pde_ff, pds_in, pde_in;

   always_comb begin
      bank_in   = bank_ff;
      count_in  = count_ff;
      wcount_in = wcount_ff;
      scan_in   = scan_ff;
      ns_in     = ns_ff;
      ne_in     = ne_ff;
      merged_in = merged_ff;
      placed_in = placed_ff;
      ovf_in    = ovf_ff;
      outs_in   = outs_ff;
      pend_in   = 1'b0;
      pds_in    = pds_ff;
      pde_in    = pde_ff;
      we        = 1'b0;
      waddr     = wcount_ff[AW-1:0];
      wds       = a;
      wde       = b;
      if (cmd.scan_clear) begin
         scan_in   = '0;
         wcount_in = '0;
         merged_in = '0;
         placed_in = 1'b0;
         ovf_in    = 1'b0;
         outs_in   = '0;
         ns_in     = s_ff;
         ne_in     = e_ff;
      end
      if (pend_ff) begin
         // Second word of a pair from the previous step.
         we        = (wcount_ff < (CW+1)'(CAPACITY));
         wds       = pds_ff;
         wde       = pde_ff;
         wcount_in = wcount_ff + 1'b1;
      end else if (cmd.scan_step) begin
         scan_in = scan_ff + 1'b1;
         unique case (op_ff)
            ist_pkg::CMD_INTERSECT: begin
               if (lo < hi) outs_in = outs_ff + 1'b1;
            end
            ist_pkg::CMD_ADD: begin
               if (merged_ff == '1) begin
                  // Gather pass: merge bounds only.
               end
               if (b < s_ff) begin
                  we = 1'b1; wcount_in = wcount_ff + 1'b1;
               end else if (a > e_ff) begin
                  if (!placed_ff) begin
                     we = 1'b1; wds = ns_ff; wde = ne_ff;
                     placed_in = 1'b1;
                     pend_in = 1'b1; pds_in = a; pde_in = b;
                  end else begin
                     we = 1'b1;
                  end
                  wcount_in = wcount_ff + 1'b1;
               end else begin
                  merged_in = merged_ff + 1'b1;
                  if (a < ns_ff) ns_in = a;
                  if (b > ne_ff) ne_in = b;
               end
            end
            ist_pkg::CMD_SUBTRACT: begin
               if (a < s_ff && b > e_ff) begin
                  we = (wcount_ff < (CW+1)'(CAPACITY));
                  wds = a; wde = s_ff;
                  wcount_in = wcount_ff + 1'b1;
                  pend_in = 1'b1; pds_in = e_ff; pde_in = b;
               end else if (a < s_ff) begin
                  we = (wcount_ff < (CW+1)'(CAPACITY));
                  wds = a; wde = (b < s_ff) ? b : s_ff;
                  wcount_in = wcount_ff + 1'b1;
               end else if (b > e_ff) begin
                  we = (wcount_ff < (CW+1)'(CAPACITY));
                  wds = (a > e_ff) ? a : e_ff; wde = b;
                  wcount_in = wcount_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
      if (cmd.commit) begin
         // Add puts the merged interval at the end when nothing above it exists.
         if (op_ff == ist_pkg::CMD_ADD && !placed_ff) begin
            we = 1'b1; wds = ns_ff; wde = ne_ff;
         end
         if (op_ff == ist_pkg::CMD_ADD && merged_ff == '0
             && count_ff == CW'(CAPACITY)) begin
            ovf_in = 1'b1;
         end else if (op_ff != ist_pkg::CMD_ADD && wcount_ff > (CW+1)'(CAPACITY)) begin
            ovf_in = 1'b1;
         end else begin
            bank_in  = ~bank_ff;
            count_in = CW'(wcount_ff);
            if (op_ff == ist_pkg::CMD_ADD && !placed_ff) count_in = CW'(wcount_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff   <= 1'b0;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         wcount_ff <= '0;
         scan_ff   <= '0;
         ovf_ff    <= 1'b0;
         outs_ff   <= '0;
      end else begin
         bank_ff   <= bank_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         wcount_ff <= wcount_in;
         scan_ff   <= scan_in;
         ovf_ff    <= ovf_in;
         outs_ff   <= outs_in;
      end
   end

   always_ff @(posedge clock) begin
      ns_ff     <= ns_in;
      ne_ff     <= ne_in;
      merged_ff <= merged_in;
      placed_ff <= placed_in;
      pds_ff    <= pds_in;
      pde_ff    <= pde_in;
      if (cmd.emit_hold) begin
         pc_s_ff <= lo;
         pc_e_ff <= hi;
      end
      if (cmd.load) begin
         op_ff  <= req_cmd;
         idx_ff <= req_index;
         s_ff   <= (rs > re) ? re : rs;
         e_ff   <= (rs > re) ? rs : re;
      end
   end

   logic [63:0] lo_w, hi_w, a_w, b_w;
   assign lo_w = 64'(pc_s_ff);
   assign hi_w = 64'(pc_e_ff);
   assign a_w  = 64'(a);
   assign b_w  = 64'(b);

   assign sts.scan_done = (scan_ff == count_ff);
   assign sts.empty_rng = (s_ff == e_ff);
   assign sts.add_full  = 1'b0;
   assign sts.sub_full  = 1'b0;
   assign sts.piece_hit = (lo < hi);
   assign sts.out_limit = (outs_ff == OCW'(ist_pkg::MAX_OUT));

   assign op          = op_ff;
   assign read_found  = (7'(idx_ff) < 7'(count_ff));
   assign piece_start = (op_ff == ist_pkg::CMD_READ) ? a_w[31:0] : lo_w[31:0];
   assign piece_end   = (op_ff == ist_pkg::CMD_READ) ? b_w[31:0] : hi_w[31:0];
   assign ovf         = ovf_ff;
   assign count       = 7'(count_ff);
endmodule

[rtl/ist_control.sv]
`timescale 1ns / 1ps
module ist_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  slot_free,
   output logic                  emit,
   output logic                  emit_last,
   output logic                  emit_piece,
   input  logic [1:0]            op,
   output ist_pkg::ist_cmd_type  cmd,
   input  ist_pkg::ist_sts_type  sts
);
   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_START  = 7'b0000010,
      S_FETCH  = 7'b0000100,
      S_STEP   = 7'b0001000,
      S_SHOW   = 7'b0010000,
      S_COMMIT = 7'b0100000,
      S_DONE   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      hit_ff, hit_in;

   always_comb begin
      state_in   = state_ff;
      hit_in     = hit_ff;
      cmd        = '0;
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_piece = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_START;
            end
         end
         S_START: begin
            cmd.scan_clear = 1'b1;
            hit_in = 1'b0;
            if (op == ist_pkg::CMD_READ) state_in = S_FETCH;
            else if (sts.empty_rng && op != ist_pkg::CMD_INTERSECT) state_in = S_DONE;
            else state_in = S_FETCH;
         end
         S_FETCH: begin
            // Memory read in flight; data is valid in the next state.
            if (op == ist_pkg::CMD_READ) begin
               cmd.read_issue = 1'b1;
               state_in = S_DONE;
            end else if (sts.scan_done || sts.out_limit) begin
               state_in = (op == ist_pkg::CMD_INTERSECT) ? S_DONE : S_COMMIT;
            end else begin
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (op == ist_pkg::CMD_INTERSECT && sts.piece_hit && hit_ff) begin
               // The held piece is not the last one, so it can go out now.
               state_in = S_SHOW;
            end else begin
               if (op == ist_pkg::CMD_INTERSECT && sts.piece_hit) begin
                  cmd.emit_hold = 1'b1;
                  hit_in = 1'b1;
               end
               cmd.scan_step = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_SHOW: begin
            emit       = 1'b1;
            emit_piece = 1'b1;
            if (slot_free) begin
               cmd.emit_hold = 1'b1;
               cmd.scan_step = 1'b1;
               state_in = S_FETCH;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            emit       = 1'b1;
            emit_last  = 1'b1;
            emit_piece = (op == ist_pkg::CMD_INTERSECT) && hit_ff;
            // Keep the read address on the index while the word waits.
            if (op == ist_pkg::CMD_READ) cmd.read_issue = 1'b1;
            if (slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end
endmodule

[rtl/interval_set_table_unit.sv]
`timescale 1ns / 1ps
// Sorted set of disjoint half-open intervals held in a pair of banked RAMs.
// Add, subtract and intersect scan the stored list once, each entry taking a
// RAM read (fetch state) then a compare (step state); intersect also spends a
// show state on every piece after the first. A stalled result port holds the
// unit. Add and subtract rebuild the list into the idle bank and swap banks
// at the end, so a dropped command leaves the set unchanged. Intersect pieces
// come out lowest first; the final word of every command carries rsp_tlast.
module interval_set_table_unit #(
   parameter int CAPACITY  = ist_pkg::CAPACITY_DEF,
   parameter int POS_WIDTH = ist_pkg::POS_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[1:0], range_start[33:2], range_end[65:34], index[71:66]
   input  logic [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // piece_start[31:0], piece_end[63:32], found[64], interval_count[71:65],
   // overflow[72], zero fill [79:73]
   output logic [79:0]  rsp_tdata,
   output logic         rsp_tlast
);
   ist_pkg::ist_cmd_type cmd;
   ist_pkg::ist_sts_type sts;
   logic [1:0]  op;
   logic [31:0] ps, pe;
   logic        rfound, ovf, emit, emit_last, emit_piece, slot_free;
   logic [6:0]  count;
   logic        vld_ff;
   logic [79:0] data_ff;
   logic        last_ff;

   ist_control u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
      .req_tready(req_tready), .slot_free(slot_free), .emit(emit),
      .emit_last(emit_last), .emit_piece(emit_piece), .op(op),
      .cmd(cmd), .sts(sts));

   ist_datapath #(.CAPACITY(CAPACITY), .POS_WIDTH(POS_WIDTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_cmd(req_tdata[1:0]), .req_start(req_tdata[33:2]),
      .req_end(req_tdata[65:34]), .req_index(req_tdata[71:66]),
      .op(op), .piece_start(ps), .piece_end(pe), .read_found(rfound),
      .ovf(ovf), .count(count));

   logic        found;
   assign found = emit_piece || (op == ist_pkg::CMD_READ && rfound);
   assign slot_free = !vld_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (slot_free) begin
         vld_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && emit) begin
         data_ff <= {7'd0, ovf, count, found, found ? pe : 32'd0, found ? ps : 32'd0};
         last_ff <= emit_last;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
endmodule

[rtl/ist_checker.sv]
`timescale 1ns / 1ps
module ist_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");
   a_nf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[64] |-> rsp_tdata[63:0] == 64'd0)
      else $error("empty result carries a piece");
   a_ovf_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[72] |-> rsp_tlast && !rsp_tdata[64])
      else $error("overflow on a non-final word");
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second command taken at once");
endmodule

bind interval_set_table_unit ist_checker u_ist_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid),
   .req_tready(req_tready), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast));
